// ===== rtl/fda_pkg.sv =====
`default_nettype none

package fda_pkg;

	localparam int NUM_SWITCHES = 3;
	localparam int COUNT_BITS   = 16;
	localparam int CFG_BITS     = 16;
	localparam int LEVEL_BITS   = 3;
	localparam int IDX_BITS     = 2;
	localparam int CMP_BITS     = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam int MODE_IDX     = 2;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST    = CFG_BITS'(20);
	localparam logic [CFG_BITS-1:0] REPEAT_SLOW_RST = CFG_BITS'(500);
	localparam logic [CFG_BITS-1:0] REPEAT_FAST_RST = CFG_BITS'(100);
	localparam logic [CFG_BITS-1:0] FAST_AFTER_RST  = CFG_BITS'(2000);

	typedef enum logic [2:0] {
		REG_DEBOUNCE    = 3'd0,
		REG_REPEAT_SLOW = 3'd1,
		REG_REPEAT_FAST = 3'd2,
		REG_FAST_AFTER  = 3'd3,
		REG_TWO_SWITCH  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_UP   = 2'd0,
		PH_DOWN = 2'd1,
		PH_SENT = 2'd2
	} phase_t;

	// timing thresholds shared by every cell
	typedef struct packed {
		logic [CFG_BITS-1:0] debounce;
		logic [CFG_BITS-1:0] repeat_slow;
		logic [CFG_BITS-1:0] repeat_fast;
		logic [CFG_BITS-1:0] fast_after;
	} timing_t;

	// handed from cell to cell along the scan
	typedef struct packed {
		logic active;
		logic fast;
	} link_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic cnt_gt(input logic [COUNT_BITS-1:0] c,
			input logic [CFG_BITS-1:0] t);
		cnt_gt = CMP_BITS'(c) > CMP_BITS'(t);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fda_cell.sv =====
`default_nettype none

module fda_cell
	import fda_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    en,
	input  wire logic    down,
	input  wire logic    rep_on,
	input  wire timing_t timing,
	input  wire logic    force_up,
	input  wire link_t   link_in,
	output link_t        link_out,
	output logic         fire
);

	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] act_q, act_d, act_inc;
	logic [COUNT_BITS-1:0] first_q, first_d, first_inc;
	logic                  fast_v;
	logic [CFG_BITS-1:0]   period;

	assign act_inc   = sat_inc(act_q);
	assign first_inc = sat_inc(first_q);

	always_comb begin
		phase_d  = phase_q;
		act_d    = act_inc;
		first_d  = first_inc;
		fire     = 1'b0;
		link_out = link_in;
		fast_v   = link_in.fast | cnt_gt(first_inc, timing.fast_after);
		period   = fast_v ? timing.repeat_fast : timing.repeat_slow;
		if (link_in.active) begin
			if (!down) begin
				phase_d       = PH_UP;
				link_out.fast = 1'b0;
			end else begin
				case (phase_q)
					PH_DOWN: begin
						if (cnt_gt(act_inc, timing.debounce)) begin
							phase_d = PH_SENT;
							fire    = 1'b1;
						end
					end
					PH_SENT: begin
						if (rep_on) begin
							link_out.fast = fast_v;
							fire          = cnt_gt(act_inc, period);
						end
					end
					default: begin
						phase_d = PH_DOWN;
						act_d   = '0;
						first_d = '0;
					end
				endcase
			end
			if (fire) begin
				act_d           = '0;
				link_out.active = 1'b0;
			end
		end
		// mode switch held in two-switch mode
		if (force_up) begin
			phase_d = PH_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UP;
			act_q   <= '0;
			first_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			act_q   <= act_d;
			first_q <= first_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/footswitch_debounce_autorepeat_top.sv =====
`default_nettype none

// footswitch debounce and autorepeat scanner: each input word is one
// millisecond tick with the sampled switch levels (up, down, mode), the
// autorepeat enable and a session timeout, and each tick gives exactly one
// result word: a report of the first switch that fires, a timeout, or
// neither. a tick is accepted every clock cycle while the output register
// is empty or its word is being taken, and its result shows in the next
// cycle; so the rate is one word per cycle as long as the result side keeps
// up. the switches form a row of cells, one per switch, scanned in index
// order within the cycle; a cell that fires stops the scan for the cells
// after it. the user must write thresholds through the cfg port only while
// no tick is in flight; the block itself does not enforce this.

module footswitch_debounce_autorepeat_top
	import fda_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// slave side: [2:0] switch_down, [3] repeat_en, [19:4] timeout_ticks
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [23:0]         s_tdata,
	// master side
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // [1:0] switch_index
	output logic [1:0]               m_tuser,   // [0] fired, [1] timed_out
	// register writes
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);

	// input word fields
	logic [LEVEL_BITS-1:0] levels;
	logic                  rep_on;
	logic [CFG_BITS-1:0]   tmo;

	assign levels = s_tdata[2:0];
	assign rep_on = s_tdata[3];
	assign tmo    = s_tdata[19:4];

	// configuration registers
	timing_t timing_q;
	logic    two_sw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.debounce    <= DEBOUNCE_RST;
			timing_q.repeat_slow <= REPEAT_SLOW_RST;
			timing_q.repeat_fast <= REPEAT_FAST_RST;
			timing_q.fast_after  <= FAST_AFTER_RST;
			two_sw_q             <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:    timing_q.debounce    <= cfg_data;
				REG_REPEAT_SLOW: timing_q.repeat_slow <= cfg_data;
				REG_REPEAT_FAST: timing_q.repeat_fast <= cfg_data;
				REG_FAST_AFTER:  timing_q.fast_after  <= cfg_data;
				REG_TWO_SWITCH:  two_sw_q             <= cfg_data[0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// handshake: the output register frees up when its word is taken
	logic accept;
	logic out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// session state shared by all cells
	logic [COUNT_BITS-1:0] sess_q, sess_inc;
	logic                  fast_q;
	logic                  timeout;

	assign sess_inc = sat_inc(sess_q);
	assign timeout  = (tmo != '0) && cnt_gt(sess_inc, tmo);

	// scan chain: a timeout keeps every cell out of the scan
	link_t                   link [NUM_SWITCHES+1];
	logic [NUM_SWITCHES-1:0] fire;
	logic [NUM_SWITCHES-1:0] down;
	logic [NUM_SWITCHES-1:0] force_up;
	logic                    mode_hit;

	assign link[0].active = !timeout;
	assign link[0].fast   = fast_q;

	// mode switch reached and held in two-switch mode forces up and down to up
	generate
		if (NUM_SWITCHES > MODE_IDX) begin : g_mode
			assign mode_hit = two_sw_q && link[MODE_IDX].active && levels[MODE_IDX];
		end else begin : g_no_mode
			assign mode_hit = 1'b0;
		end
	endgenerate

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SWITCHES; gi++) begin : g_cell
			// switches beyond the level field read as up
			if (gi < LEVEL_BITS) begin : g_lvl
				assign down[gi] = levels[gi];
			end else begin : g_nolvl
				assign down[gi] = 1'b0;
			end
			if (gi < MODE_IDX) begin : g_force
				assign force_up[gi] = mode_hit;
			end else begin : g_noforce
				assign force_up[gi] = 1'b0;
			end

			fda_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (accept),
				.down     (down[gi]),
				.rep_on   (rep_on),
				.timing   (timing_q),
				.force_up (force_up[gi]),
				.link_in  (link[gi]),
				.link_out (link[gi+1]),
				.fire     (fire[gi])
			);
		end
	endgenerate

	// at most one cell fires, so the index is a plain or of the hits
	logic                any_fire;
	logic [IDX_BITS-1:0] idx_d;

	assign any_fire = |fire;

	always_comb begin
		idx_d = '0;
		for (int i = 0; i < NUM_SWITCHES; i++) begin
			if (fire[i]) begin
				idx_d = idx_d | IDX_BITS'(i);
			end
		end
	end

	// a report or a timeout starts a new session at the slow period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_q <= '0;
			fast_q <= 1'b0;
		end else if (accept) begin
			if (timeout || any_fire) begin
				sess_q <= '0;
				fast_q <= 1'b0;
			end else begin
				sess_q <= sess_inc;
				fast_q <= link[NUM_SWITCHES].fast;
			end
		end
	end

	// output register
	logic                fired_q;
	logic                timed_out_q;
	logic [IDX_BITS-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fired_q     <= any_fire;
			timed_out_q <= timeout;
			idx_q       <= idx_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8-IDX_BITS){1'b0}}, idx_q};
	assign m_tuser  = {timed_out_q, fired_q};

endmodule

`default_nettype wire

// ===== rtl/fda_chk.sv =====
`default_nettype none

module fda_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser
);

	// a tick never both reports a switch and times out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("fired and timed_out together");

	// no report means index zero
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata[1:0] == 2'd0))
		else $error("index set without a report");

	// every accepted tick shows a result in the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> m_tvalid)
		else $error("accepted tick gave no result");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind footswitch_debounce_autorepeat_top fda_chk u_fda_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
